### design/sphere_image_charge_defines.svh
// Assertion macros shared by the sphere image charge RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SPHERE_IMAGE_CHARGE_DEFINES_SVH
`define SPHERE_IMAGE_CHARGE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define SIC_CHECK(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SIC_CHECK_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/sic_pkg.sv
// Package for the sphere image charge block: widths, codes, shared types.
// No dependencies; imported by every module of the block.
package sic_pkg;

    localparam int IDX_W     = 16;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 3;
    localparam int RAD_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int S_W       = 2 * RAD_W;          // squared length, inside sphere
    localparam int SUM_W     = S_W + 2;            // sum of three squares
    localparam int ROOT_W    = S_W / 2;            // integer square root
    localparam int PROD_W    = VAL_W + RAD_W;      // |q| * R
    localparam int NUM_W     = RAD_W + S_W;        // |d| * R^2
    localparam int OFF_QW    = VAL_W;              // offset quotient bits
    localparam int CHG_QW    = RAD_W;              // charge quotient bits
    localparam int OUT_W     = IDX_W + 4 * VAL_W;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_CENTRE    = 3'd1;
    localparam logic [ST_W-1:0] ST_UNCHARGED = 3'd2;
    localparam logic [ST_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [ST_W-1:0] ST_SHELL     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CZ   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP = 3'd4;

    localparam logic [RAD_W-1:0] RESET_RADIUS = 31'd65536;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][VAL_W-1:0] center;
        logic [RAD_W-1:0]      radius;
        logic [S_W-1:0]        r2;
        logic                  skip;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [IDX_W-1:0]      idx;
        logic [ST_W-1:0]       status;
        logic                  qneg;
        logic [2:0]            dneg;
        logic [S_W-1:0]        s;
        logic [2:0][NUM_W-1:0] num;
        logic [PROD_W-1:0]     qmr;
    } t_front;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ST_W-1:0]  status;
        logic             qneg;
        logic [2:0]       dneg;
    } t_side;

    typedef struct packed {
        logic              ovf;
        logic [OFF_QW-1:0] quo;
    } t_offq;

    typedef struct packed {
        logic [VAL_W-1:0]      chg;
        logic [2:0][VAL_W-1:0] img;
        logic [ST_W-1:0]       status;
        logic [IDX_W-1:0]      idx;
    } t_result;

    // clamp a two-guard-bit value to the signed 32-bit range
    function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W+1:0] v);
        logic [VAL_W-1:0] res;
        if (v[VAL_W+1:VAL_W-1] == 3'b000 || v[VAL_W+1:VAL_W-1] == 3'b111) begin
            res = v[VAL_W-1:0];
        end else begin
            res = v[VAL_W+1] ? VAL_MIN : VAL_MAX;
        end
        return res;
    endfunction

endpackage

### design/sic_front.sv
// Front end: offsets, magnitudes, squares and products, status decision.
// Four register stages; uses sic_pkg.
module sic_front import sic_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [2:0][VAL_W-1:0] i_pos,
    input  logic [VAL_W-1:0]      i_charge,
    input  t_cfg                  i_cfg,
    output t_front                o_front
);

    // stage 1
    logic                  r_v1;
    logic [IDX_W-1:0]      r_idx1;
    logic [2:0][VAL_W:0]   r_d1, n_d1;
    logic [VAL_W-1:0]      r_q1;
    // stage 2
    logic                  r_v2;
    logic [IDX_W-1:0]      r_idx2;
    logic [2:0][VAL_W-1:0] r_mag2, n_mag2;
    logic [2:0]            r_dneg2;
    logic                  r_out2, n_out2, r_cen2, r_unch2, r_qneg2;
    logic [VAL_W-1:0]      r_qm2;
    // stage 3
    logic                  r_v3;
    logic [IDX_W-1:0]      r_idx3;
    logic [2:0][S_W-1:0]   r_sq3, r_phi3, r_plo3;
    logic [2:0]            r_dneg3;
    logic                  r_out3, r_cen3, r_unch3, r_qneg3;
    logic [PROD_W-1:0]     r_qmr3;
    // stage 4
    logic                  r_v4;
    t_front                r_f4, n_f4;
    logic [SUM_W-1:0]      n_s;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d1[k] = {i_pos[k][VAL_W-1], i_pos[k]}
                    - {i_cfg.center[k][VAL_W-1], i_cfg.center[k]};
        end
    end

    always_comb begin
        n_out2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_mag2[k] = r_d1[k][VAL_W] ? VAL_W'(-r_d1[k]) : r_d1[k][VAL_W-1:0];
            if (n_mag2[k] > {1'b0, i_cfg.radius}) begin
                n_out2 = 1'b1;
            end
        end
    end

    always_comb begin
        n_s = SUM_W'(r_sq3[0]) + SUM_W'(r_sq3[1]) + SUM_W'(r_sq3[2]);
        n_f4 = '0;
        n_f4.idx  = r_idx3;
        n_f4.qneg = r_qneg3;
        n_f4.dneg = r_dneg3;
        n_f4.s    = n_s[S_W-1:0];
        n_f4.qmr  = r_qmr3;
        for (int k = 0; k < 3; k++) begin
            n_f4.num[k] = {r_phi3[k], {RAD_W{1'b0}}} + NUM_W'(r_plo3[k]);
        end
        if (r_unch3) begin
            n_f4.status = ST_UNCHARGED;
        end else if (r_cen3) begin
            n_f4.status = ST_CENTRE;
        end else if (r_out3 || n_s > SUM_W'(i_cfg.r2)) begin
            n_f4.status = ST_OUTSIDE;
        end else if (n_s == SUM_W'(i_cfg.r2)) begin
            n_f4.status = ST_SHELL;
        end else begin
            n_f4.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx1 <= i_idx;
            r_d1   <= n_d1;
            r_q1   <= i_charge;

            r_idx2  <= r_idx1;
            r_mag2  <= n_mag2;
            r_out2  <= n_out2;
            r_cen2  <= (r_d1 == '0);
            r_unch2 <= i_cfg.skip && (r_q1 == '0);
            r_qneg2 <= r_q1[VAL_W-1];
            r_qm2   <= r_q1[VAL_W-1] ? (~r_q1 + VAL_W'(1)) : r_q1;
            for (int k = 0; k < 3; k++) begin
                r_dneg2[k] <= r_d1[k][VAL_W];
                r_sq3[k]   <= S_W'(r_mag2[k][RAD_W-1:0]) * S_W'(r_mag2[k][RAD_W-1:0]);
                r_phi3[k]  <= S_W'(r_mag2[k][RAD_W-1:0]) * S_W'(i_cfg.r2[S_W-1:RAD_W]);
                r_plo3[k]  <= S_W'(r_mag2[k][RAD_W-1:0]) * S_W'(i_cfg.r2[RAD_W-1:0]);
            end

            r_idx3  <= r_idx2;
            r_dneg3 <= r_dneg2;
            r_out3  <= r_out2;
            r_cen3  <= r_cen2;
            r_unch3 <= r_unch2;
            r_qneg3 <= r_qneg2;
            r_qmr3  <= PROD_W'(r_qm2) * PROD_W'(i_cfg.radius);

            r_f4 <= n_f4;
        end
    end

    always_comb begin
        o_front = r_f4;
        o_front.valid = r_v4;
    end

endmodule

### design/sic_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses sic_pkg for default widths.
module sic_isqrt import sic_pkg::*; #(
    parameter int IN_W   = S_W,
    parameter int ROOT_W = S_W / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_s,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root
);

    localparam int RW = ROOT_W + 2;

    logic              r_v    [ROOT_W];
    logic [RW-1:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [IN_W-1:0]   r_s    [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stg
        logic              p_v;
        logic [RW-1:0]     p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [IN_W-1:0]   p_s;
        logic [RW+1:0]     t, trial;
        logic              ge;

        if (j == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_s    = i_s;
        end else begin : g_next
            assign p_v    = r_v[j-1];
            assign p_rem  = r_rem[j-1];
            assign p_root = r_root[j-1];
            assign p_s    = r_s[j-1];
        end

        // bring down the next bit pair, try root*4+1
        assign t     = {p_rem, p_s[IN_W-1-2*j -: 2]};
        assign trial = {{(RW-ROOT_W){1'b0}}, p_root, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? RW'(t - trial) : t[RW-1:0];
                r_root[j] <= {p_root[ROOT_W-2:0], ge};
                r_s[j]    <= p_s;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

### design/sic_div.sv
// Pipelined restoring divider with quotient overflow flag.
// One quotient bit per stage after a range check stage; uses sic_pkg.
module sic_div import sic_pkg::*; #(
    parameter int NW = PROD_W,
    parameter int DW = ROOT_W,
    parameter int QW = CHG_QW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          r_v   [QW+1];
    logic [DW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];

    logic [HW-1:0] hi;
    assign hi = i_num[NW-1:QW];

    // range check: quotient would not fit in QW bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (CW'(hi) >= CW'(i_den));
            r_rem[0] <= DW'(hi);
            r_den[0] <= i_den;
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_stg
        logic [DW:0] t;
        logic        ge;

        assign t  = {r_rem[j-1], r_low[j-1][QW-j]};
        assign ge = (t >= {1'b0, r_den[j-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? DW'(t - {1'b0, r_den[j-1]}) : t[DW-1:0];
                r_den[j] <= r_den[j-1];
                r_low[j] <= r_low[j-1];
                r_quo[j] <= {r_quo[j-1][QW-2:0], ge};
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_quo[QW];
    assign o_ovf   = r_ovf[QW];

endmodule

### design/sic_delay.sv
// Stallable delay line with a travelling valid bit.
// Aligns side data with the arithmetic units; uses sic_pkg.
module sic_delay import sic_pkg::*; #(
    parameter int W = IDX_W,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic         r_v [N];
    logic [W-1:0] r_d [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j < N; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_data;
            for (int j = 1; j < N; j++) begin
                r_d[j] <= r_d[j-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_data  = r_d[N-1];

endmodule

### design/sic_skid.sv
// Two-entry output buffer; holds the pipeline only when both entries are full.
// Uses sic_pkg.
module sic_skid import sic_pkg::*; #(
    parameter int W = OUT_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_en,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0]   r_cnt, n_cnt;
    logic [W-1:0] r_head, r_tail;
    logic         push, pop;

    assign o_en    = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != CNT_EMPTY);
    assign o_data  = r_head;
    assign push    = i_valid && o_en;
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_EMPTY;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == CNT_FULL) begin
            r_head <= r_tail;
        end else if (push && (r_cnt == CNT_EMPTY || pop)) begin
            r_head <= i_data;
        end
        if (push && r_cnt == CNT_ONE && !pop) begin
            r_tail <= i_data;
        end
    end

endmodule

### design/sphere_image_charge.sv
// Top level of the grounded-sphere Kelvin image charge block.
// Depends on sic_pkg, sic_front, sic_isqrt, sic_div, sic_delay, sic_skid.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-----------------------------------
//  s_axis    | in  | tvalid / tready        | tdata: particle_index, pos_x,
//            |     |                        |        pos_y, pos_z, charge
//  m_axis    | out | tvalid / tready        | tdata: result_index, image_x,
//            |     |                        |        image_y, image_z, image_charge
//            |     |                        | tuser: status
//  cfg       | in  | we, no back-pressure   | idx 0..4: cx, cy, cz, radius, skip
//
// One item per cycle sustained while the output buffer has room. From acceptance to
// tvalid: 4 front stages, 31 square-root stages, 32 charge-divider stages (the longest
// chain; offset division runs beside the root), one output stage, then the buffer.
// Reset is synchronous, active low; it clears valid bits, centre and skip, and sets the radius to 65536.
// A downstream stall fills the two-entry output buffer; the whole pipeline
// holds only when that buffer is full, so nothing is lost or repeated.
`include "sphere_image_charge_defines.svh"
module sphere_image_charge import sic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [15:0] particle_index, [47:16] pos_x, [79:48] pos_y,
    // [111:80] pos_z, [143:112] charge
    input  logic [OUT_W-1:0]     i_s_axis_tdata,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [15:0] result_index, [47:16] image_x, [79:48] image_y,
    // [111:80] image_z, [143:112] image_charge
    output logic [OUT_W-1:0]     o_m_axis_tdata,
    // [2:0] status
    output logic [ST_W-1:0]      o_m_axis_tuser,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    // offsets finish before the charge path; side data spans the longest path
    localparam int SIDE_DLY = ROOT_W + CHG_QW + 1;
    localparam int OFF_DLY  = SIDE_DLY - (OFF_QW + 1);

    // ---------------- configuration ----------------
    logic [2:0][VAL_W-1:0] r_center;
    logic [RAD_W-1:0]      r_radius;
    logic [S_W-1:0]        r_r2;
    logic                  r_skip;
    t_cfg                  cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_radius <= RESET_RADIUS;
            r_r2     <= S_W'(RESET_RADIUS) * S_W'(RESET_RADIUS);
            r_skip   <= 1'b0;
        end else begin
            // R^2 follows the radius in the next cycle; config changes only when idle is a user rule, not enforced
            r_r2 <= S_W'(r_radius) * S_W'(r_radius);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CX:   r_center[0] <= i_cfg_data;
                    REG_CY:   r_center[1] <= i_cfg_data;
                    REG_CZ:   r_center[2] <= i_cfg_data;
                    REG_RAD:  r_radius    <= i_cfg_data[RAD_W-1:0];
                    REG_SKIP: r_skip      <= i_cfg_data[0];
                    default:  ;
                endcase
            end
        end
    end

    assign cfg = '{center: r_center, radius: r_radius, r2: r_r2, skip: r_skip};

    // ---------------- pipeline control ----------------
    logic en;
    assign o_s_axis_tready = en;

    // ---------------- front end ----------------
    logic [2:0][VAL_W-1:0] in_pos;
    t_front                front;

    assign in_pos = i_s_axis_tdata[IDX_W +: 3*VAL_W];

    sic_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_axis_tvalid),
        .i_idx    (i_s_axis_tdata[IDX_W-1:0]),
        .i_pos    (in_pos),
        .i_charge (i_s_axis_tdata[IDX_W+3*VAL_W +: VAL_W]),
        .i_cfg    (cfg),
        .o_front  (front)
    );

    // ---------------- length and charge ----------------
    logic              sq_v, qd_v, cd_v, cd_ovf;
    logic [ROOT_W-1:0] sq_root;
    logic [PROD_W-1:0] qd_qmr;
    logic [CHG_QW-1:0] cd_quo;

    sic_isqrt #(.IN_W(S_W), .ROOT_W(ROOT_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front.valid),
        .i_s     (front.s),
        .o_valid (sq_v),
        .o_root  (sq_root)
    );

    sic_delay #(.W(PROD_W), .N(ROOT_W)) u_qmr_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front.valid),
        .i_data  (front.qmr),
        .o_valid (qd_v),
        .o_data  (qd_qmr)
    );

    // |q|*R / L, flagged when it reaches 2^31
    sic_div #(.NW(PROD_W), .DW(ROOT_W), .QW(CHG_QW)) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (qd_qmr),
        .i_den   (sq_root),
        .o_valid (cd_v),
        .o_quo   (cd_quo),
        .o_ovf   (cd_ovf)
    );

    // ---------------- image offsets ----------------
    logic [2:0]   od_v;
    t_offq [2:0]  od_q, oq_dly;
    logic         oq_v;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        // |d|*R^2 / s, flagged at 2^32 (the sum saturates anyway)
        sic_div #(.NW(NUM_W), .DW(S_W), .QW(OFF_QW)) u_odiv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (front.valid),
            .i_num   (front.num[k]),
            .i_den   (front.s),
            .o_valid (od_v[k]),
            .o_quo   (od_q[k].quo),
            .o_ovf   (od_q[k].ovf)
        );
    end

    sic_delay #(.W($bits(t_offq) * 3), .N(OFF_DLY)) u_off_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (&od_v),
        .i_data  (od_q),
        .o_valid (oq_v),
        .o_data  (oq_dly)
    );

    // ---------------- side data ----------------
    t_side side_in, side;
    logic  side_v;

    assign side_in = '{idx: front.idx, status: front.status,
                       qneg: front.qneg, dneg: front.dneg};

    sic_delay #(.W($bits(t_side)), .N(SIDE_DLY)) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front.valid),
        .i_data  (side_in),
        .o_valid (side_v),
        .o_data  (side)
    );

    // ---------------- result assembly ----------------
    t_result          n_fin, r_fin;
    logic             r_fin_v;
    logic [VAL_W+1:0] off_ext, c_ext, sum;
    logic [VAL_W-1:0] cm;

    always_comb begin
        n_fin = '0;
        n_fin.idx    = side.idx;
        n_fin.status = side.status;
        off_ext = '0;
        c_ext   = '0;
        sum     = '0;
        cm      = {1'b0, cd_quo};
        if (side.status == ST_OK) begin
            for (int k = 0; k < 3; k++) begin
                off_ext = {2'b00, oq_dly[k].quo};
                c_ext   = {{2{r_center[k][VAL_W-1]}}, r_center[k]};
                sum     = side.dneg[k] ? (c_ext - off_ext) : (c_ext + off_ext);
                if (oq_dly[k].ovf) begin
                    n_fin.img[k] = side.dneg[k] ? VAL_MIN : VAL_MAX;
                end else begin
                    n_fin.img[k] = sat_val(sum);
                end
            end
            // image charge carries the opposite sign of q
            if (side.qneg) begin
                n_fin.chg = cd_ovf ? VAL_MAX : cm;
            end else begin
                n_fin.chg = cd_ovf ? VAL_MIN : (~cm + VAL_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (en) begin
            r_fin_v <= side_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin <= n_fin;
        end
    end

    // ---------------- output buffer ----------------
    t_result out_res;

    sic_skid #(.W($bits(t_result))) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fin_v),
        .i_data  (r_fin),
        .o_en    (en),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {out_res.chg, out_res.img, out_res.idx};
    assign o_m_axis_tuser = out_res.status;

    // ---------------- checks ----------------
    `SIC_CHECK(a_root_align, i_clk, i_rst_n, sq_v == qd_v, "root and q*R out of step")
    `SIC_CHECK(a_tail_align, i_clk, i_rst_n, (cd_v == side_v) && (oq_v == side_v), "result paths out of step")
    `SIC_CHECK_IMP(a_skip_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tdata[OUT_W-1:IDX_W] == '0, "image set on a skipped particle")

endmodule

### bench/sphere_image_charge_test.sv
// Self-checking bench for sphere_image_charge: streams particles, predicts each image.
// Depends on sic_pkg and the sphere_image_charge RTL; needs no other files.
module sphere_image_charge_test import sic_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 68;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [VAL_W-1:0] chg;
        logic [VAL_W-1:0] iz;
        logic [VAL_W-1:0] iy;
        logic [VAL_W-1:0] ix;
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] idx;
    } t_image;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [OUT_W-1:0] i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]  o_m_axis_tuser;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0] i_cfg_data;

    // predictor copy of the configuration
    logic signed [VAL_W-1:0] sphere_centre [3];
    logic [RAD_W-1:0]        sphere_radius;
    logic                    skip_zero_q;

    t_image images_due[$];
    int     mismatches;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     recv_hold;
    bit     timed_out;

    sphere_image_charge uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact floor division of a 128-bit product by a 64-bit divisor
    function automatic logic [63:0] div_floor(input logic [127:0] num, input logic [63:0] den);
        logic [127:0] q;
        q = num / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic [VAL_W-1:0] clamp32(input logic signed [65:0] v);
        logic [VAL_W-1:0] res;
        if (v > 66'sd2147483647) begin
            res = VAL_MAX;
        end else if (v < -66'sd2147483648) begin
            res = VAL_MIN;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_image predict_image(input logic [IDX_W-1:0] idx,
                                             input logic signed [VAL_W-1:0] px,
                                             input logic signed [VAL_W-1:0] py,
                                             input logic signed [VAL_W-1:0] pz,
                                             input logic signed [VAL_W-1:0] q);
        t_image res;
        logic signed [33:0] d [3];
        logic [33:0] m [3];
        logic [63:0] r, r2, s, len, cm, off;
        logic signed [65:0] sv;
        bit outside;
        res = '0;
        res.idx = idx;
        r = {33'd0, sphere_radius};
        r2 = r * r;
        outside = 1'b0;
        d[0] = 34'(px) - 34'(sphere_centre[0]);
        d[1] = 34'(py) - 34'(sphere_centre[1]);
        d[2] = 34'(pz) - 34'(sphere_centre[2]);
        for (int k = 0; k < 3; k++) begin
            m[k] = d[k] < 0 ? 34'(-d[k]) : 34'(d[k]);
            if ({30'd0, m[k]} > r) outside = 1'b1;
        end
        if (skip_zero_q && q == 0) begin
            res.status = ST_UNCHARGED;
        end else if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            res.status = ST_CENTRE;
        end else if (outside) begin
            res.status = ST_OUTSIDE;
        end else begin
            s = 0;
            for (int k = 0; k < 3; k++) s = s + {30'd0, m[k]} * {30'd0, m[k]};
            if (s > r2) begin
                res.status = ST_OUTSIDE;
            end else if (s == r2) begin
                res.status = ST_SHELL;
            end else begin
                res.status = ST_OK;
                len = floor_sqrt(s);
                cm = (64'(q < 0 ? -65'(q) : 65'(q)) * r) / len;
                if (cm > 64'h8000_0000) cm = 64'h8000_0000;
                sv = q > 0 ? -66'(cm) : 66'(cm);
                res.chg = clamp32(sv);
                for (int k = 0; k < 3; k++) begin
                    off = div_floor({94'd0, m[k]} * {64'd0, r2}, s);
                    sv = 66'(sphere_centre[k]) + (d[k] < 0 ? -66'(off) : 66'(off));
                    if (k == 0) res.ix = clamp32(sv);
                    if (k == 1) res.iy = clamp32(sv);
                    if (k == 2) res.iz = clamp32(sv);
                end
            end
        end
        return res;
    endfunction

    // one register write, mirrored into the predictor; the caller drops the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_CX:   sphere_centre[0] = val;
            REG_CY:   sphere_centre[1] = val;
            REG_CZ:   sphere_centre[2] = val;
            REG_RAD:  sphere_radius = val[RAD_W-1:0];
            REG_SKIP: skip_zero_q = val[0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(input logic [VAL_W-1:0] cx, input logic [VAL_W-1:0] cy,
                              input logic [VAL_W-1:0] cz, input logic [RAD_W-1:0] rad,
                              input logic skip);
        write_reg(REG_CX, cx);
        write_reg(REG_CY, cy);
        write_reg(REG_CZ, cz);
        write_reg(REG_RAD, {1'b0, rad});
        write_reg(REG_SKIP, {31'd0, skip});
        i_cfg_we <= 1'b0;
    endtask

    // send one particle; idles first at the current sender rate
    task automatic send_particle(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] px,
                                 input logic [VAL_W-1:0] py, input logic [VAL_W-1:0] pz,
                                 input logic [VAL_W-1:0] q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {q, pz, py, px, idx};
        images_due.push_back(predict_image(idx, px, py, pz, q));
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // stop sending, wait for the pipe to drain, then for its latency
    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (images_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // offset around the sphere centre, mostly inside, some beyond the radius
    function automatic logic [VAL_W-1:0] near(input int k, input logic [RAD_W-1:0] rad);
        logic signed [33:0] off;
        logic signed [65:0] v;
        case ($urandom_range(9))
            0: off = $signed({1'b0, $urandom}) - 34'sd2147483648;
            1: off = 34'(rad) + $urandom_range(3);
            default: off = 34'($urandom_range(rad)) - 34'($urandom_range(rad)) / 2;
        endcase
        if ($urandom_range(1)) off = -off;
        if ($urandom_range(1)) off = off / 2;
        v = 66'(sphere_centre[k]) + 66'(off);
        return clamp32(v);
    endfunction

    function automatic logic [VAL_W-1:0] rand_charge;
        case ($urandom_range(7))
            0: return '0;
            1: return VAL_MAX;
            2: return VAL_MIN;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++) begin
            send_particle(16'($urandom), near(0, sphere_radius), near(1, sphere_radius),
                          near(2, sphere_radius), rand_charge());
        end
    endtask

    // extremes and every status at the reset sphere and two shifted ones
    task automatic test_directed;
        logic [VAL_W-1:0] one;
        one = 32'h0001_0000;
        send_particle(16'h0000, 0, 0, 0, one);                  // at centre
        send_particle(16'hFFFF, one, 0, 0, one);                // on shell
        send_particle(16'h1234, 32'h0000_8000, 0, 0, one);      // computed
        send_particle(16'h0001, 32'h0000_8000, 0, 0, 0);        // zero charge computed
        send_particle(16'h0002, 32'h0000_0001, 0, 0, VAL_MAX);  // saturates
        send_particle(16'h0003, 32'hFFFF_FFFF, 0, 0, VAL_MIN);
        send_particle(16'h0004, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN); // outside
        send_particle(16'h0005, 32'h0000_A000, 32'h0000_A000, 32'h0000_A000, one);
        send_particle(16'h0006, 0, 32'hFFFF_0000, 0, 32'hFFFF_0000);
        drain();
        set_sphere(VAL_MAX, VAL_MIN, 32'h0001_0000, 31'h7FFF_FFFF, 1'b1);
        send_particle(16'h0010, VAL_MAX, VAL_MIN, 32'h0001_0000, 0);   // skipped
        send_particle(16'h0011, VAL_MAX, VAL_MIN, 32'h0001_0000, one); // centre
        send_particle(16'h0012, 0, 0, 32'h0001_0000, one);
        send_particle(16'h0013, VAL_MAX, VAL_MIN, 32'h0001_0001, VAL_MIN);
        send_particle(16'h0014, 32'h7FFF_0000, 32'h8000_FFFF, 0, VAL_MAX);
        send_particle(16'h0015, 32'h0000_0000, VAL_MIN, 32'h0001_0000, one);
        drain();
        set_sphere(32'h0000_0010, 32'h0000_0020, 32'h0000_0030, 31'd1, 1'b0);
        send_particle(16'h0020, 32'h0000_0011, 32'h0000_0020, 32'h0000_0030, one);
        send_particle(16'h0021, 32'h0000_0010, 32'h0000_0020, 32'h0000_0030, 0);
        send_particle(16'h0022, 32'h0000_0011, 32'h0000_0021, 32'h0000_0030, one);
        drain();
    endtask

    task automatic test_random_spheres;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_sphere(0, 0, 0, 31'h0001_0000, 1'b0);
                1: set_sphere($urandom, $urandom, $urandom, 31'($urandom), 1'b1);
                2: set_sphere(VAL_MIN, VAL_MAX, VAL_MIN, 31'h7FFF_FFFF, 1'b0);
                3: set_sphere($urandom, $urandom, $urandom, 31'($urandom_range(255) + 1), 1'b1);
                default: set_sphere($urandom, $urandom, $urandom,
                                    31'($urandom_range(32'h7FFF_FFFF, 1)), 1'($urandom));
            endcase
            send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 3 ? 23 : 87) : 0;
            recv_stall_pct = (p % 4 == 2) ? 87 : (p % 4 == 3 ? 23 : 0);
            random_batch(190);
            drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off long enough to fill the pipe and stall the input
    task automatic test_backpressure;
        recv_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_batch(100);
        join
        drain();                 // sender pauses until every image is back
        random_batch(40);
        drain();
    endtask

    // receiver: stalls at random, compares each result with the oldest prediction
    always @(posedge i_clk) begin
        t_image got;
        t_image want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[143:16], o_m_axis_tuser, o_m_axis_tdata[15:0]};
            if (images_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected image, index %h", got.idx);
            end else begin
                want = images_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("idx %h st %0d x %h y %h z %h q %h / want %h %0d %h %h %h %h",
                                 got.idx, got.status, got.ix, got.iy, got.iz, got.chg,
                                 want.idx, want.status, want.ix, want.iy, want.iz, want.chg);
                end
            end
        end
        i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_CX;
        i_cfg_data      <= '0;
        sphere_centre   = '{0, 0, 0};
        sphere_radius   = RESET_RADIUS;
        skip_zero_q     = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        recv_hold       = 1'b0;
        timed_out       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_spheres();
        test_backpressure();
        if (mismatches == 0 && images_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
